FILE: rtl/core/fsbc_pkg.sv
// ----------------------------------------------------------------------------
// fsbc_pkg
// Shared types for the FIFO sector buffer cache directory: commands, result
// kinds, sequencer states and the structs passed between modules.
// ----------------------------------------------------------------------------
package fsbc_pkg;

	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_DIRTY  = 2'd2,
		CMD_FLUSH  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_LOOKUP    = 2'd0,
		KIND_READ      = 2'd1,
		KIND_WRITEBACK = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_CHK,
		ST_ADV,
		ST_WRITE,
		ST_MARK,
		ST_EMIT
	} state_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] sector;
		logic [5:0]  slot;
		logic        hit;
		logic        last;
	} res_t;

	typedef struct packed {
		logic valid;
		res_t res;
	} out_req_t;

	typedef struct packed {
		logic tag_we;
		logic dirty_we;
		logic dirty_val;
	} wr_ctl_t;

endpackage

FILE: rtl/core/fifo_sector_buffer_cache_core.sv
// Insert writes the tag, first reading the oldest entry when the ring is
// full and emitting its write-back when it is dirty; mark-dirty writes the
// dirty bit. Lookup and flush scan the live entries by directory read, tag
// compare and ring step; results leave while the output register is free.
// One command is in work at a time; input stays low until the command ends.
// Reset: asynchronous, active low; clears control, ring pointer, count, out valid.
// ----------------------------------------------------------------------------
// fifo_sector_buffer_cache_core
// Tag directory of a sector cache kept as a FIFO ring: lookup, insert with
// eviction and write-back, mark dirty, and flush of dirty entries.
// ----------------------------------------------------------------------------
module fifo_sector_buffer_cache_core
	import fsbc_pkg::*;
#(
	parameter int CACHE_SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [31:0] sector,
	input  logic [5:0]  slot_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [31:0] disk_sector,
	output logic [5:0]  slot,
	output logic        hit,
	output logic        last
);

	localparam int SW = $clog2(CACHE_SLOTS);

	out_req_t      req;
	wr_ctl_t       wr;
	logic [SW-1:0] waddr, raddr;
	logic [31:0]   tag_wdata, rd_tag;
	logic          rd_dirty;
	logic          res_take;
	logic          out_valid_q;
	res_t          out_q;

	// Sequencer: one command at a time, one ring entry per scan step
	fsbc_ctrl #(.CACHE_SLOTS(CACHE_SLOTS)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.sector     (sector),
		.slot_index (slot_index),
		.req        (req),
		.res_take   (res_take),
		.wr         (wr),
		.waddr      (waddr),
		.tag_wdata  (tag_wdata),
		.raddr      (raddr),
		.rd_tag     (rd_tag),
		.rd_dirty   (rd_dirty)
	);

	// Directory storage: tags and dirty bits
	fsbc_dir_ram #(.DEPTH(CACHE_SLOTS)) u_ram (
		.clk       (clk),
		.wr        (wr),
		.waddr     (waddr),
		.tag_wdata (tag_wdata),
		.raddr     (raddr),
		.rd_tag    (rd_tag),
		.rd_dirty  (rd_dirty)
	);

	// Output register: take a new result when empty or when the current
	// transfer completes in this cycle, so the sequencer rarely waits.
	assign res_take = req.valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the payload until its transfer completes
	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= req.res;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = out_q.kind;
	assign disk_sector = out_q.sector;
	assign slot        = out_q.slot;
	assign hit         = out_q.hit;
	assign last        = out_q.last;

endmodule

FILE: rtl/core/fsbc_dir_ram.sv
// ----------------------------------------------------------------------------
// fsbc_dir_ram
// Tag and dirty-bit arrays of the directory, one shared write address and
// one read address, registered read data.
// ----------------------------------------------------------------------------
module fsbc_dir_ram
	import fsbc_pkg::*;
#(
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  wr_ctl_t       wr,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   tag_wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rd_tag,
	output logic          rd_dirty
);

	logic [31:0] tag_mem [DEPTH];
	logic        dirty_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.tag_we) begin
			tag_mem[waddr] <= tag_wdata;
		end
		rd_tag <= tag_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (wr.dirty_we) begin
			dirty_mem[waddr] <= wr.dirty_val;
		end
		rd_dirty <= dirty_mem[raddr];
	end

endmodule

FILE: rtl/core/fsbc_ctrl.sv
// ----------------------------------------------------------------------------
// fsbc_ctrl
// Command sequencer: walks the ring one entry at a time through the shared
// tag compare and ring-pointer step, and issues result requests.
// ----------------------------------------------------------------------------
module fsbc_ctrl
	import fsbc_pkg::*;
#(
	parameter int CACHE_SLOTS = 64,
	localparam int SW = $clog2(CACHE_SLOTS),
	localparam int CW = $clog2(CACHE_SLOTS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    command,
	input  logic [31:0]   sector,
	input  logic [5:0]    slot_index,
	output out_req_t      req,
	input  logic          res_take,
	output wr_ctl_t       wr,
	output logic [SW-1:0] waddr,
	output logic [31:0]   tag_wdata,
	output logic [SW-1:0] raddr,
	input  logic [31:0]   rd_tag,
	input  logic          rd_dirty
);

	localparam int XW = (SW > 6) ? SW + 1 : 7;
	localparam int PW = (SW > 6) ? SW : 6;
	localparam logic [SW-1:0] LastPos = SW'(CACHE_SLOTS - 1);
	localparam logic [CW-1:0] FullCnt = CW'(CACHE_SLOTS);

	state_t        state_q, state_d, ret_q;
	cmd_t          cmd_q;
	logic [31:0]   sec_q;
	logic [5:0]    sidx_q;
	logic [SW-1:0] oldest_q, pos_q, i_q;
	logic [CW-1:0] count_q;
	logic          pend_v_q;
	logic [31:0]   pend_sec_q;
	logic [SW-1:0] pend_pos_q;
	res_t          res_q;

	logic          in_fire, match, last_idx, mark_ok;
	logic [SW-1:0] pos_inc, oldest_inc, wpos;
	logic [SW:0]   wsum;
	logic [XW-1:0] sidx_x, oldest_x, off_x;

	function automatic logic [5:0] slot6(input logic [SW-1:0] p);
		logic [PW-1:0] t;
		t = PW'(p);
		return t[5:0];
	endfunction

	assign in_fire = in_valid && in_ready;

	// Shared compare and ring step
	assign match      = (rd_tag == sec_q);
	assign last_idx   = (CW'(i_q) + CW'(1)) == count_q;
	assign pos_inc    = (pos_q == LastPos) ? '0 : pos_q + SW'(1);
	assign oldest_inc = (oldest_q == LastPos) ? '0 : oldest_q + SW'(1);
	assign wsum       = (SW + 1)'(oldest_q) + (SW + 1)'(count_q);
	assign wpos       = (wsum >= (SW + 1)'(CACHE_SLOTS)) ?
	                    SW'(wsum - (SW + 1)'(CACHE_SLOTS)) : SW'(wsum);

	// Ring offset of the slot to mark dirty
	assign sidx_x   = XW'(sidx_q);
	assign oldest_x = XW'(oldest_q);
	assign off_x    = (sidx_x < oldest_x) ? sidx_x - oldest_x + XW'(CACHE_SLOTS)
	                                      : sidx_x - oldest_x;
	assign mark_ok  = (sidx_x < XW'(CACHE_SLOTS)) && (off_x < XW'(count_q));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					unique case (cmd_t'(command))
						CMD_LOOKUP: state_d = (count_q == '0) ? ST_EMIT : ST_RD;
						CMD_INSERT: state_d = (count_q == FullCnt) ? ST_RD : ST_WRITE;
						CMD_DIRTY:  state_d = ST_MARK;
						CMD_FLUSH:  state_d = (count_q == '0) ? ST_IDLE : ST_RD;
					endcase
				end
			end
			ST_RD: state_d = ST_CHK;
			ST_CHK: begin
				unique case (cmd_q)
					CMD_LOOKUP: state_d = match ? ST_EMIT : ST_ADV;
					CMD_INSERT: state_d = rd_dirty ? ST_EMIT : ST_WRITE;
					CMD_FLUSH:  state_d = (rd_dirty && pend_v_q) ? ST_EMIT : ST_ADV;
					CMD_DIRTY:  state_d = ST_IDLE;
				endcase
			end
			ST_ADV: begin
				if (!last_idx) begin
					state_d = ST_RD;
				end else if (cmd_q == CMD_LOOKUP || pend_v_q) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_WRITE: state_d = ST_EMIT;
			ST_MARK:  state_d = ST_IDLE;
			ST_EMIT:  state_d = res_take ? ret_q : ST_EMIT;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		req.valid    = (state_q == ST_EMIT);
		req.res      = res_q;
		wr.tag_we    = (state_q == ST_WRITE);
		wr.dirty_we  = (state_q == ST_WRITE) || (state_q == ST_MARK && mark_ok);
		wr.dirty_val = (state_q == ST_MARK);
		waddr        = (state_q == ST_MARK) ? SW'(sidx_x) : wpos;
		tag_wdata    = sec_q;
		raddr        = pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ret_q    <= ST_IDLE;
			cmd_q    <= CMD_LOOKUP;
			oldest_q <= '0;
			count_q  <= '0;
			pend_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						cmd_q    <= cmd_t'(command);
						pend_v_q <= 1'b0;
						ret_q    <= ST_IDLE;
					end
				end
				ST_CHK: begin
					if (cmd_q == CMD_INSERT) begin
						oldest_q <= oldest_inc;
						count_q  <= FullCnt - CW'(1);
						ret_q    <= ST_WRITE;
					end else if (cmd_q == CMD_FLUSH && rd_dirty) begin
						pend_v_q <= 1'b1;
						ret_q    <= ST_ADV;
					end else begin
						ret_q <= ST_IDLE;
					end
				end
				ST_ADV: begin
					if (last_idx) begin
						pend_v_q <= 1'b0;
						ret_q    <= ST_IDLE;
					end
				end
				ST_WRITE: begin
					count_q <= count_q + CW'(1);
					ret_q   <= ST_IDLE;
				end
				ST_RD, ST_MARK, ST_EMIT: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers: hold the latched item, scan position and result
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					sec_q  <= sector;
					sidx_q <= slot_index;
					pos_q  <= oldest_q;
					i_q    <= '0;
					res_q  <= '{kind: KIND_LOOKUP, sector: sector, slot: 6'd0,
					           hit: 1'b0, last: 1'b1};
				end
			end
			ST_CHK: begin
				unique case (cmd_q)
					CMD_LOOKUP: begin
						res_q <= '{kind: KIND_LOOKUP, sector: sec_q, slot: slot6(pos_q),
						           hit: 1'b1, last: 1'b1};
					end
					CMD_INSERT: begin
						res_q <= '{kind: KIND_WRITEBACK, sector: rd_tag, slot: slot6(pos_q),
						           hit: 1'b0, last: 1'b0};
					end
					CMD_FLUSH: begin
						if (rd_dirty) begin
							res_q <= '{kind: KIND_WRITEBACK, sector: pend_sec_q,
							           slot: slot6(pend_pos_q), hit: 1'b0, last: 1'b0};
							pend_sec_q <= rd_tag;
							pend_pos_q <= pos_q;
						end
					end
					CMD_DIRTY: begin
					end
				endcase
			end
			ST_ADV: begin
				if (!last_idx) begin
					i_q   <= i_q + SW'(1);
					pos_q <= pos_inc;
				end else if (cmd_q == CMD_LOOKUP) begin
					res_q <= '{kind: KIND_LOOKUP, sector: sec_q, slot: 6'd0,
					           hit: 1'b0, last: 1'b1};
				end else begin
					res_q <= '{kind: KIND_WRITEBACK, sector: pend_sec_q,
					           slot: slot6(pend_pos_q), hit: 1'b0, last: 1'b1};
				end
			end
			ST_WRITE: begin
				res_q <= '{kind: KIND_READ, sector: sec_q, slot: slot6(wpos),
				           hit: 1'b0, last: 1'b1};
			end
			ST_RD, ST_MARK, ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FullCnt)
		else $error("entry count above cache size");

	a_write_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WRITE |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the ring");

	a_pend_flush: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> cmd_q == CMD_FLUSH)
		else $error("pending write-back outside a flush");

	a_hit_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.res.hit |-> req.res.kind == KIND_LOOKUP && req.res.last)
		else $error("hit flag on a non-lookup result");
`endif

endmodule
